// ===== sv/oamf_pkg.sv =====
`default_nettype none

package oamf_pkg;

	localparam int MEM_BYTES  = 65536;
	localparam int MEM_AW     = $clog2(MEM_BYTES);
	localparam int BANK_DEPTH = MEM_BYTES / 2;
	localparam int BANK_AW    = MEM_AW - 1;

	localparam logic [1:0] ACT_MEM_WR = 2'd0;
	localparam logic [1:0] ACT_REG_WR = 2'd1;
	localparam logic [1:0] ACT_DECODE = 2'd2;

	localparam logic [2:0] MODE_REG      = 3'd0;
	localparam logic [2:0] MODE_DEF      = 3'd1;
	localparam logic [2:0] MODE_AINC     = 3'd2;
	localparam logic [2:0] MODE_AINC_DEF = 3'd3;
	localparam logic [2:0] MODE_ADEC     = 3'd4;
	localparam logic [2:0] MODE_ADEC_DEF = 3'd5;
	localparam logic [2:0] MODE_IDX      = 3'd6;
	localparam logic [2:0] MODE_IDX_DEF  = 3'd7;

	localparam logic [2:0] PC_REG = 3'd7;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ISSUE = 6'b000010,
		ST_INDEX = 6'b000100,
		ST_DEREF = 6'b001000,
		ST_FETCH = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// ===== sv/oamf_ram.sv =====
`default_nettype none

module oamf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/operand_address_mode_fetch.sv =====
// Loads go from idle straight to finish. Decodes pass through issue, then: register mode
// to finish; deferred/autoincrement/autodecrement via fetch; their deferred forms via deref
// and fetch; index via index and fetch; index deferred via index, deref and fetch. A new
// transaction is taken only in idle, once the last result is registered. The operand
// sequencer issues one word read per cycle into the two byte-bank RAMs (even/odd bytes).
// Reset clears the register file, state and out_valid; memory is undefined until written.
`default_nettype none

module operand_address_mode_fetch
	import oamf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [5:0]  specifier,
	input  wire logic        byte_mode,
	input  wire logic [15:0] load_address,
	input  wire logic [15:0] load_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] operand_address,
	output logic      [15:0] operand_value,
	output logic             is_register
);

	state_t state_q, state_d;

	logic [15:0] rf_q [8];
	logic [5:0]  spec_q;
	logic        byte_q;
	logic [1:0]  action_q;
	logic [15:0] adr_q;
	logic [15:0] val_q;
	logic        isreg_q;
	logic        out_valid_q;
	logic        rd_odd_q;

	logic        acc;
	logic        fin_fire;
	logic [2:0]  mode;
	logic [2:0]  reg_sel;
	logic [15:0] step;
	logic [15:0] rf_r;
	logic [15:0] rf_pc;
	logic [15:0] rd_addr;
	logic [15:0] word;

	logic        rf_we;
	logic [2:0]  rf_wa;
	logic [15:0] rf_wd;

	logic               we_even, we_odd;
	logic [BANK_AW-1:0] waddr, idx, raddr_even;
	logic [7:0]         rd_even, rd_odd;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign mode      = spec_q[5:3];
	assign reg_sel   = spec_q[2:0];
	assign step      = byte_q ? 16'd1 : 16'd2;
	assign rf_r      = rf_q[reg_sel];
	assign rf_pc     = rf_q[PC_REG];

	// byte banks: even addresses in one RAM, odd in the other
	assign waddr      = load_address[MEM_AW-1:1];
	assign we_even    = acc && (action == ACT_MEM_WR) && !load_address[0];
	assign we_odd     = acc && (action == ACT_MEM_WR) && load_address[0];
	assign idx        = rd_addr[MEM_AW-1:1];
	assign raddr_even = rd_addr[0] ? idx + BANK_AW'(1) : idx;

	oamf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (waddr),
		.wdata (load_data[7:0]),
		.raddr (raddr_even),
		.rdata (rd_even)
	);

	oamf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (waddr),
		.wdata (load_data[7:0]),
		.raddr (idx),
		.rdata (rd_odd)
	);

	assign word = rd_odd_q ? {rd_even, rd_odd} : {rd_odd, rd_even};

	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_ISSUE: begin
				if (mode inside {MODE_ADEC, MODE_ADEC_DEF}) begin
					rd_addr = rf_r - step;
				end else if (mode inside {MODE_IDX, MODE_IDX_DEF}) begin
					rd_addr = rf_pc;
				end else begin
					rd_addr = rf_r;
				end
			end
			ST_INDEX: rd_addr = rf_r + word;
			ST_DEREF: rd_addr = word;
			default:  rd_addr = '0;
		endcase
	end

	// single register-file write port
	always_comb begin
		rf_we = 1'b0;
		rf_wa = reg_sel;
		rf_wd = '0;
		if (acc && (action == ACT_REG_WR)) begin
			rf_we = 1'b1;
			rf_wa = load_address[2:0];
			rf_wd = load_data;
		end else if (state_q == ST_ISSUE) begin
			if (mode inside {MODE_AINC, MODE_AINC_DEF}) begin
				rf_we = 1'b1;
				rf_wd = rf_r + step;
			end else if (mode inside {MODE_ADEC, MODE_ADEC_DEF}) begin
				rf_we = 1'b1;
				rf_wd = rf_r - step;
			end else if (mode inside {MODE_IDX, MODE_IDX_DEF}) begin
				rf_we = 1'b1;
				rf_wa = PC_REG;
				rf_wd = rf_pc + 16'd2;
			end
		end else if (fin_fire && (action_q == ACT_DECODE) && rf_pc[0]) begin
			// round an odd PC up
			rf_we = 1'b1;
			rf_wa = PC_REG;
			rf_wd = rf_pc + 16'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = (action == ACT_DECODE) ? ST_ISSUE : ST_FIN;
				end
			end
			ST_ISSUE: begin
				if (mode == MODE_REG) begin
					state_d = ST_FIN;
				end else if (mode inside {MODE_AINC_DEF, MODE_ADEC_DEF}) begin
					state_d = ST_DEREF;
				end else if (mode inside {MODE_IDX, MODE_IDX_DEF}) begin
					state_d = ST_INDEX;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_INDEX: state_d = (mode == MODE_IDX_DEF) ? ST_DEREF : ST_FETCH;
			ST_DEREF: state_d = ST_FETCH;
			ST_FETCH: state_d = ST_FIN;
			ST_FIN: begin
				if (fin_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (rf_we) begin
				rf_q[rf_wa] <= rf_wd;
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_odd_q <= rd_addr[0];
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					spec_q   <= specifier;
					byte_q   <= byte_mode;
					action_q <= action;
					adr_q    <= '0;
					val_q    <= '0;
					isreg_q  <= 1'b0;
				end
			end
			ST_ISSUE: begin
				if (mode == MODE_REG) begin
					adr_q   <= {13'b0, reg_sel};
					val_q   <= rf_r;
					isreg_q <= 1'b1;
				end else begin
					adr_q <= rd_addr;
				end
			end
			ST_INDEX: adr_q <= rd_addr;
			ST_DEREF: adr_q <= rd_addr;
			ST_FETCH: val_q <= word;
			default: ;
		endcase
		if (fin_fire) begin
			operand_address <= adr_q;
			operand_value   <= val_q;
			is_register     <= isreg_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== tb/operand_address_mode_fetch_check.sv =====
module operand_address_mode_fetch_check
	import oamf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [5:0]  specifier,
	input  wire logic        byte_mode,
	input  wire logic [15:0] load_address,
	input  wire logic [15:0] load_data,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] operand_address,
	input  wire logic [15:0] operand_value,
	input  wire logic        is_register,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [15:0] addr;
		logic [15:0] value;
		logic        is_reg;
	} operand_t;

	// Shadow machine state; the stimulus side also reads it to avoid unwritten bytes.
	logic [15:0] gpr [8];
	logic [7:0]  mem_byte [MEM_BYTES];
	bit          mem_set [MEM_BYTES];
	operand_t    operand_q [$];

	function automatic logic [15:0] mem_word(input logic [15:0] a);
		return {mem_byte[a + 16'd1], mem_byte[a]};
	endfunction

	task automatic resolve(input logic [1:0] act, input logic [5:0] spec, input logic bm,
			input logic [15:0] la, input logic [15:0] ld, output operand_t res);
		logic [15:0] step;
		logic [15:0] disp;
		logic [2:0]  r;
		step = bm ? 16'd1 : 16'd2;
		r = spec[2:0];
		res = '0;
		case (act)
			ACT_MEM_WR: begin
				mem_byte[la] = ld[7:0];
				mem_set[la] = 1'b1;
			end
			ACT_REG_WR: gpr[la[2:0]] = ld;
			ACT_DECODE: begin
				case (spec[5:3])
					MODE_REG: begin
						res.addr = {13'd0, r};
						res.value = gpr[r];
						res.is_reg = 1'b1;
					end
					MODE_DEF: begin
						res.addr = gpr[r];
						res.value = mem_word(res.addr);
					end
					MODE_AINC: begin
						res.addr = gpr[r];
						res.value = mem_word(res.addr);
						gpr[r] = gpr[r] + step;
					end
					MODE_AINC_DEF: begin
						res.addr = mem_word(gpr[r]);
						res.value = mem_word(res.addr);
						gpr[r] = gpr[r] + step;
					end
					MODE_ADEC: begin
						gpr[r] = gpr[r] - step;
						res.addr = gpr[r];
						res.value = mem_word(res.addr);
					end
					MODE_ADEC_DEF: begin
						gpr[r] = gpr[r] - step;
						res.addr = mem_word(gpr[r]);
						res.value = mem_word(res.addr);
					end
					MODE_IDX: begin
						disp = mem_word(gpr[PC_REG]);
						gpr[PC_REG] = gpr[PC_REG] + 16'd2;
						res.addr = gpr[r] + disp;
						res.value = mem_word(res.addr);
					end
					default: begin
						disp = mem_word(gpr[PC_REG]);
						gpr[PC_REG] = gpr[PC_REG] + 16'd2;
						res.addr = mem_word(gpr[r] + disp);
						res.value = mem_word(res.addr);
					end
				endcase
				// round an odd PC up after every decode
				if (gpr[PC_REG][0])
					gpr[PC_REG] = gpr[PC_REG] + 16'd1;
			end
			default: ;
		endcase
	endtask

	task automatic compare(input string name, input logic [15:0] want, input logic [15:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, seen);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		operand_t want;
		operand_t head;
		if (!arst_n) begin
			foreach (gpr[i])
				gpr[i] = '0;
			operand_q.delete();
			pending = 0;
		end else begin
			// retire results before taking new transactions in the same cycle
			if (out_valid && out_ready) begin
				if (operand_q.size() == 0) begin
					$display("%0t: result with no transaction pending: addr %h value %h reg %b",
						$time, operand_address, operand_value, is_register);
					errors++;
				end else begin
					head = operand_q.pop_front();
					compare("operand_address", head.addr, operand_address);
					compare("operand_value", head.value, operand_value);
					compare("is_register", {15'd0, head.is_reg}, {15'd0, is_register});
				end
			end
			if (in_valid && in_ready) begin
				resolve(action, specifier, byte_mode, load_address, load_data, want);
				operand_q.push_back(want);
			end
			pending = operand_q.size();
		end
	end

endmodule

// ===== tb/operand_address_mode_fetch_test.sv =====
module operand_address_mode_fetch_test;
	import oamf_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = ACT_MEM_WR;
	logic [5:0]  specifier = '0;
	logic        byte_mode = 1'b0;
	logic [15:0] load_address = '0;
	logic [15:0] load_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b1;
	logic [15:0] operand_address;
	logic [15:0] operand_value;
	logic        is_register;
	int          errors;
	int          pending;

	bit calm = 1'b0;
	int stall_left = 0;
	int sent = 0;
	int n_fill = 0;
	int n_act [4];
	int n_mode [8];

	operand_address_mode_fetch i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.specifier       (specifier),
		.byte_mode       (byte_mode),
		.load_address    (load_address),
		.load_data       (load_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.operand_address (operand_address),
		.operand_value   (operand_value),
		.is_register     (is_register)
	);

	operand_address_mode_fetch_check i_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.specifier       (specifier),
		.byte_mode       (byte_mode),
		.load_address    (load_address),
		.load_data       (load_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.operand_address (operand_address),
		.operand_value   (operand_value),
		.is_register     (is_register),
		.errors          (errors),
		.pending         (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#8000000;
		$display("operand_address_mode_fetch_test: errors");
		$finish;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [15:0] pick_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return 16'($urandom_range(0, 255));
		if (sel == 4)
			return 16'($urandom_range(16'hFFF0, 16'hFFFF));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_addr();
		if ($urandom_range(0, 2) != 0)
			return 16'($urandom_range(0, 255));
		return 16'($urandom);
	endfunction

	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	function automatic logic [15:0] word_at(input logic [15:0] a);
		return {i_check.mem_byte[a + 16'd1], i_check.mem_byte[a]};
	endfunction

	function automatic bit word_hole(input logic [15:0] a, output logic [15:0] hole);
		logic [15:0] a1;
		a1 = a + 16'd1;
		hole = i_check.mem_set[a] ? a1 : a;
		return !(i_check.mem_set[a] && i_check.mem_set[a1]);
	endfunction

	// Walk the reads a decode would make and return the first byte never written.
	function automatic bit find_hole(input logic [5:0] spec, input bit bm,
			output logic [15:0] hole);
		logic [15:0] base;
		logic [15:0] step;
		logic [15:0] a;
		logic [15:0] pc;
		int hops;
		base = i_check.gpr[spec[2:0]];
		step = bm ? 16'd1 : 16'd2;
		hops = 0;
		hole = '0;
		a = base;
		case (spec[5:3])
			MODE_REG: return 1'b0;
			MODE_DEF, MODE_AINC: a = base;
			MODE_AINC_DEF: begin
				a = base;
				hops = 1;
			end
			MODE_ADEC: a = base - step;
			MODE_ADEC_DEF: begin
				a = base - step;
				hops = 1;
			end
			default: begin
				pc = i_check.gpr[PC_REG];
				if (word_hole(pc, hole))
					return 1'b1;
				if (spec[2:0] == PC_REG)
					base = pc + 16'd2;
				a = base + word_at(pc);
				hops = (spec[5:3] == MODE_IDX_DEF) ? 1 : 0;
			end
		endcase
		for (int i = 0; i < hops; i++) begin
			if (word_hole(a, hole))
				return 1'b1;
			a = word_at(a);
		end
		return word_hole(a, hole);
	endfunction

	// Call at a falling edge; returns once the transaction is accepted.
	task automatic put(input logic [1:0] act, input logic [5:0] spec, input bit bm,
			input logic [15:0] la, input logic [15:0] ld);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		specifier <= spec;
		byte_mode <= bm;
		load_address <= la;
		load_data <= ld;
		do @(posedge clk); while (!in_ready);
		sent++;
		n_act[act]++;
	endtask

	task automatic load(input logic [1:0] act, input logic [15:0] la, input logic [15:0] ld);
		@(negedge clk);
		put(act, 6'($urandom), 1'($urandom), la, ld);
	endtask

	task automatic decode(input logic [5:0] spec, input bit bm);
		logic [15:0] hole;
		forever begin
			@(negedge clk);
			if (!find_hole(spec, bm, hole))
				break;
			put(ACT_MEM_WR, 6'($urandom), 1'($urandom), hole, 16'($urandom));
			n_fill++;
		end
		put(ACT_DECODE, spec, bm, 16'($urandom), 16'($urandom));
		n_mode[spec[5:3]]++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int sel;
		bit drained_mid;
		drained_mid = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// extremes, wraparound at the top of memory, every mode, PC rounding
		load(ACT_REG_WR, 16'hFFF8, 16'hFFFF);
		load(ACT_REG_WR, 16'h0001, 16'h0000);
		load(ACT_MEM_WR, 16'hFFFF, 16'hFF34);
		load(ACT_MEM_WR, 16'h0000, 16'h0012);
		decode({MODE_DEF, 3'd0}, 1'b0);
		decode({MODE_REG, 3'd0}, 1'b1);
		decode({MODE_AINC, 3'd0}, 1'b0);
		decode({MODE_ADEC, 3'd1}, 1'b1);
		decode({MODE_ADEC, 3'd1}, 1'b0);
		load(ACT_NONE, 16'hFFFF, 16'hFFFF);
		load(ACT_REG_WR, {13'h1FFF, PC_REG}, 16'h0101);
		decode({MODE_IDX, PC_REG}, 1'b0);
		decode({MODE_IDX_DEF, 3'd2}, 1'b0);
		decode({MODE_AINC, PC_REG}, 1'b1);
		decode({MODE_AINC_DEF, 3'd3}, 1'b0);
		decode({MODE_ADEC_DEF, 3'd4}, 1'b1);
		decode({MODE_ADEC, PC_REG}, 1'b1);
		decode({MODE_DEF, PC_REG}, 1'b0);
		decode({MODE_IDX_DEF, PC_REG}, 1'b1);
		load(ACT_REG_WR, 16'h0005, 16'h0000);
		decode({MODE_REG, 3'd5}, 1'b0);
		decode({MODE_AINC_DEF, PC_REG}, 1'b1);
		drain();

		while (sent < 1450) begin
			calm = (sent >= 700 && sent < 850);
			if (!drained_mid && sent >= 1000) begin
				drain();
				drained_mid = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 55)
				decode(6'($urandom), 1'($urandom));
			else if (sel < 70)
				load(ACT_REG_WR, 16'($urandom), pick_word());
			else if (sel < 95)
				load(ACT_MEM_WR, pick_addr(), 16'($urandom));
			else
				load(ACT_NONE, 16'($urandom), 16'($urandom));
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && pending != 0; i++)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("covered %0d transactions: %0d decodes, %0d register loads, %0d memory loads",
			sent, n_act[ACT_DECODE], n_act[ACT_REG_WR], n_act[ACT_MEM_WR]);
		$display("  %0d fills, %0d unused actions, per mode %0d %0d %0d %0d %0d %0d %0d %0d",
			n_fill, n_act[ACT_NONE], n_mode[0], n_mode[1], n_mode[2], n_mode[3],
			n_mode[4], n_mode[5], n_mode[6], n_mode[7]);
		if (errors == 0 && pending == 0)
			$display("operand_address_mode_fetch_test: clean");
		else
			$display("operand_address_mode_fetch_test: errors");
		$finish;
	end

endmodule
